@@ hw/rtl/incremental_pid_heater_pwm_assert.svh @@
// Assertion macros for the checker file of the heater controller.
// Needs nothing else; each file that asserts includes this header.
`ifndef INCREMENTAL_PID_HEATER_PWM_ASSERT_SVH
`define INCREMENTAL_PID_HEATER_PWM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IHP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define IHP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ihp_pkg.sv @@
// Shared types, register codes and constants of the heater controller.
// Depends on nothing; used by every RTL module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ihp_pkg;

  localparam int DUTY_W    = 7;
  localparam int TEMP_W    = 10;
  localparam int ERR_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int CMP_W     = 8;
  localparam int PROD_W    = 30;
  localparam int TERM_W    = 22;
  localparam int SUM_W     = 24;

  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
  localparam logic [8:0]        MIN_TARGET = 9'd45;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_GAIN_P = 3'd1,
    REG_GAIN_I = 3'd2,
    REG_GAIN_D = 3'd3,
    REG_BAND   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]  target_temp;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [7:0]  boost_band;
  } cfg_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic signed [ERR_W-1:0] err;
    logic                    in_band;
  } pid_res_t;

  // Divide a Q8.8 product by 256, rounding toward zero.
  function automatic logic signed [TERM_W-1:0] q8_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    biased = p[PROD_W-1] ? (p + PROD_W'(255)) : p;
    return TERM_W'(biased >>> 8);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ihp_cfg_regs.sv @@
// Configuration register file of the heater controller.
// Depends on ihp_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none

module ihp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [ihp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ihp_pkg::CFG_DAT_W-1:0]   cfg_data,
  output ihp_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp <= 9'd0;
      cfg.gain_p      <= 16'd20480;
      cfg.gain_i      <= 16'd307;
      cfg.gain_d      <= 16'd205;
      cfg.boost_band  <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_index)
        ihp_pkg::REG_TARGET: cfg.target_temp <= cfg_data[8:0];
        ihp_pkg::REG_GAIN_P: cfg.gain_p      <= cfg_data;
        ihp_pkg::REG_GAIN_I: cfg.gain_i      <= cfg_data;
        ihp_pkg::REG_GAIN_D: cfg.gain_d      <= cfg_data;
        ihp_pkg::REG_BAND:   cfg.boost_band  <= cfg_data[7:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ihp_pid_calc.sv @@
// Combinational incremental PID step: error, band checks, three gain terms, clamp.
// Depends on ihp_pkg for cfg_t, pid_res_t and the Q8.8 truncation helper.
`timescale 1ns / 1ps
`default_nettype none

module ihp_pid_calc (
  input  ihp_pkg::cfg_t                          cfg,
  input  logic signed [ihp_pkg::TEMP_W-1:0]      measured,
  input  logic signed [ihp_pkg::ERR_W-1:0]       err_prev,
  input  logic signed [ihp_pkg::ERR_W-1:0]       err_prev2,
  input  logic [ihp_pkg::DUTY_W-1:0]             prev_duty,
  output ihp_pkg::pid_res_t                      res
);

  logic signed [ihp_pkg::ERR_W-1:0]  err;
  logic signed [11:0]                dp;
  logic signed [12:0]                dd;
  logic signed [ihp_pkg::PROD_W-1:0] gp_x, gi_x, gd_x, dp_x, e_x, dd_x;
  logic signed [ihp_pkg::PROD_W-1:0] prod_p, prod_i, prod_d;
  logic signed [ihp_pkg::SUM_W-1:0]  sum;
  logic                              err_neg, err_high;

  assign err = $signed({2'b00, cfg.target_temp}) - $signed({measured[ihp_pkg::TEMP_W-1], measured});

  assign err_neg  = err[ihp_pkg::ERR_W-1];
  assign err_high = err > $signed({3'b000, cfg.boost_band});

  // First and second differences of the error history.
  assign dp = $signed({err[ihp_pkg::ERR_W-1], err}) - $signed({err_prev[ihp_pkg::ERR_W-1], err_prev});
  assign dd = $signed({{2{err[ihp_pkg::ERR_W-1]}}, err})
            - $signed({err_prev[ihp_pkg::ERR_W-1], err_prev, 1'b0})
            + $signed({{2{err_prev2[ihp_pkg::ERR_W-1]}}, err_prev2});

  assign gp_x = $signed({14'd0, cfg.gain_p});
  assign gi_x = $signed({14'd0, cfg.gain_i});
  assign gd_x = $signed({14'd0, cfg.gain_d});
  assign dp_x = $signed({{18{dp[11]}}, dp});
  assign e_x  = $signed({{19{err[ihp_pkg::ERR_W-1]}}, err});
  assign dd_x = $signed({{17{dd[12]}}, dd});

  assign prod_p = gp_x * dp_x;
  assign prod_i = gi_x * e_x;
  assign prod_d = gd_x * dd_x;

  assign sum = ihp_pkg::SUM_W'(ihp_pkg::q8_trunc(prod_p))
             + ihp_pkg::SUM_W'(ihp_pkg::q8_trunc(prod_i))
             + ihp_pkg::SUM_W'(ihp_pkg::q8_trunc(prod_d))
             + $signed({17'd0, prev_duty});

  always_comb begin
    res.err     = err;
    res.in_band = !err_neg && !err_high;
    if (err_neg) begin
      res.duty = '0;
    end else if (err_high) begin
      res.duty = ihp_pkg::DUTY_MAX;
    end else if (sum[ihp_pkg::SUM_W-1]) begin
      res.duty = '0;
    end else if (sum > $signed({17'd0, ihp_pkg::DUTY_MAX})) begin
      res.duty = ihp_pkg::DUTY_MAX;
    end else begin
      res.duty = sum[ihp_pkg::DUTY_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/incremental_pid_heater_pwm.sv @@
// Incremental PID heater controller with time-proportional PWM. Every input
// item is one timer tick that carries the measured temperature and optional
// start and stop pulses (stop wins). Each item yields exactly one result item
// with the heater bit, the duty in percent, the run flag and a flag that marks
// ticks on which a control step ran; while running, that happens on every
// (CONTROL_INTERVAL+1)-th tick. The block takes one item per clock cycle while
// the output is not stalled; an item first lands in the input register, then the
// whole tick (run flag, interval counter, the PID step with its three parallel
// Q8.8 gain multipliers, the clamp and the PWM compare) is evaluated from there
// into the result register, from which the result is handed out. The result
// register frees the input side, so a waiting result does not block the next
// tick unless the output stays stalled. Configuration writes are accepted on
// every cycle and should be issued only while no ticks are in flight.
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_heater_pwm #(
  parameter int CONTROL_INTERVAL = 100,
  parameter int PWM_TOP          = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Tick input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ihp_pkg::TEMP_W-1:0]    measured_temp,
  input  logic                                 start_pulse,
  input  logic                                 stop_pulse,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 heater_on,
  output logic [ihp_pkg::DUTY_W-1:0]           duty_now,
  output logic                                 running,
  output logic                                 control_updated,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ihp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ihp_pkg::CFG_DAT_W-1:0]        cfg_data
);

  localparam int IC_W  = $clog2(CONTROL_INTERVAL + 1);
  localparam int PWM_W = $clog2(PWM_TOP + 1);

  ihp_pkg::cfg_t     cfg;
  ihp_pkg::pid_res_t pid;

  // Input register.
  logic                              s1_valid;
  logic signed [ihp_pkg::TEMP_W-1:0] s1_meas;
  logic                              s1_start;
  logic                              s1_stop;
  logic                              s1_fire;

  // Controller state carried from tick to tick.
  logic                              run_flag;
  logic [IC_W-1:0]                   interval_count;
  logic [PWM_W-1:0]                  pwm_count;
  logic [ihp_pkg::DUTY_W-1:0]        duty;
  logic [ihp_pkg::DUTY_W-1:0]        prev_duty;
  logic signed [ihp_pkg::ERR_W-1:0]  err_prev;
  logic signed [ihp_pkg::ERR_W-1:0]  err_prev2;

  // Next values for the tick held in the input register.
  logic                              run_pre;
  logic                              step_now;
  logic                              run_next;
  logic [IC_W-1:0]                   interval_count_next;
  logic [PWM_W-1:0]                  pwm_count_next;
  logic [ihp_pkg::DUTY_W-1:0]        duty_next;
  logic                              heater_next;

  assign cfg_ready = 1'b1;

  ihp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ihp_pid_calc u_pid (
    .cfg       (cfg),
    .measured  (s1_meas),
    .err_prev  (err_prev),
    .err_prev2 (err_prev2),
    .prev_duty (prev_duty),
    .res       (pid)
  );

  // The held tick moves on when the result register is empty or being read.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_comb begin
    // Pulses act before the tick is counted; stop takes priority.
    if (s1_stop) begin
      run_pre = 1'b0;
    end else if (s1_start) begin
      run_pre = 1'b1;
    end else begin
      run_pre = run_flag;
    end

    step_now            = run_pre && (interval_count >= IC_W'(CONTROL_INTERVAL));
    interval_count_next = interval_count;
    duty_next           = duty;
    if (run_pre) begin
      interval_count_next = step_now ? '0 : interval_count + 1'b1;
    end
    if (step_now) begin
      duty_next = pid.duty;
    end

    // A set-point below the minimum ends the run, even though the step ran.
    run_next = run_pre && !(step_now && (cfg.target_temp < ihp_pkg::MIN_TARGET));

    heater_next    = 1'b0;
    pwm_count_next = pwm_count;
    if (run_next) begin
      heater_next    = {{(ihp_pkg::CMP_W - PWM_W){1'b0}}, pwm_count}
                     < {{(ihp_pkg::CMP_W - ihp_pkg::DUTY_W){1'b0}}, duty_next};
      pwm_count_next = (pwm_count < PWM_W'(PWM_TOP)) ? pwm_count + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      run_flag       <= 1'b0;
      interval_count <= '0;
      pwm_count      <= '0;
      duty           <= '0;
      prev_duty      <= '0;
      err_prev       <= '0;
      err_prev2      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_meas  <= measured_temp;
        s1_start <= start_pulse;
        s1_stop  <= stop_pulse;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        out_valid       <= 1'b1;
        heater_on       <= heater_next;
        duty_now        <= duty_next;
        running         <= run_next;
        control_updated <= step_now;

        run_flag       <= run_next;
        interval_count <= interval_count_next;
        pwm_count      <= pwm_count_next;
        duty           <= duty_next;
        // Only a step inside the band advances the history.
        if (step_now && pid.in_band) begin
          prev_duty <= pid.duty;
          err_prev  <= pid.err;
          err_prev2 <= err_prev;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ihp_checker.sv @@
// Port-level checker for the heater controller, bound to its top level.
// Depends on ihp_pkg and the assertion macros in the shared header.
`timescale 1ns / 1ps
`default_nettype none

`include "incremental_pid_heater_pwm_assert.svh"

module ihp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       heater_on,
  input logic [ihp_pkg::DUTY_W-1:0] duty_now,
  input logic                       running,
  input logic                       control_updated
);

  `IHP_ASSERT_IMP(a_duty_range, clk, rst, out_valid, duty_now <= ihp_pkg::DUTY_MAX, "duty above maximum")
  `IHP_ASSERT_IMP(a_heat_runs, clk, rst, out_valid && heater_on, running, "heater on while stopped")
  `IHP_ASSERT_IMP(a_heat_duty, clk, rst, out_valid && heater_on, duty_now != '0, "heater on at zero duty")
  `IHP_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(duty_now) && $stable(heater_on) && $stable(running) && $stable(control_updated), "stalled result changed")

endmodule

bind incremental_pid_heater_pwm ihp_checker u_ihp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .heater_on       (heater_on),
  .duty_now        (duty_now),
  .running         (running),
  .control_updated (control_updated)
);

`default_nettype wire
